// ===== sv/mfr_pkg.sv =====
// Shared types, register codes and the median network for the 3x3 median filter.
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

   localparam int CSR_DATA_W = 13;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic        is_border;
      logic        last_of_run;
   } rsp_type;

   localparam int NET_LEN = 19;

   localparam logic [0:NET_LEN-1][3:0] NET_A = {
      4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
      4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
   };
   localparam logic [0:NET_LEN-1][3:0] NET_B = {
      4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
      4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
   };

   // compare-exchange network; the middle element ends in slot four
   function automatic logic [7:0] median9(input logic [8:0][7:0] v);
      logic [8:0][7:0] p;
      logic [7:0]      t;
      p = v;
      for (int k = 0; k < NET_LEN; k++) begin
         if (p[NET_A[k]] > p[NET_B[k]]) begin
            t           = p[NET_A[k]];
            p[NET_A[k]] = p[NET_B[k]];
            p[NET_B[k]] = t;
         end
      end
      return p[4];
   endfunction

endpackage

`default_nettype wire

// ===== sv/mfr_line_buffer.sv =====
// Two line stores with registered read and same-address write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module mfr_line_buffer
   import mfr_pkg::*;
#(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire pix_type           wr_near,
   input  wire pix_type           wr_far,
   output pix_type                near_q,
   output pix_type                far_q
);

   pix_type near_mem [DEPTH];
   pix_type far_mem  [DEPTH];

   logic collide;

   assign collide = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         near_mem[wr_addr] <= wr_near;
         far_mem[wr_addr]  <= wr_far;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         near_q <= collide ? wr_near : near_mem[rd_addr];
         far_q  <= collide ? wr_far  : far_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/mfr_window.sv =====
// 3x3 pixel window with per-channel median output.
`timescale 1ns / 1ps
`default_nettype none

module mfr_window
   import mfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    shift_en,
   input  wire pix_type far_pix,
   input  wire pix_type near_pix,
   input  wire pix_type new_pix,
   output pix_type      med_pix
);

   pix_type         window_ff [9];
   logic [8:0][7:0] red_set;
   logic [8:0][7:0] green_set;
   logic [8:0][7:0] blue_set;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (shift_en) begin
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= far_pix;
         window_ff[3] <= window_ff[4];
         window_ff[4] <= window_ff[5];
         window_ff[5] <= near_pix;
         window_ff[6] <= window_ff[7];
         window_ff[7] <= window_ff[8];
         window_ff[8] <= new_pix;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         red_set[i]   = window_ff[i].red;
         green_set[i] = window_ff[i].green;
         blue_set[i]  = window_ff[i].blue;
      end
      med_pix.red   = median9(red_set);
      med_pix.green = median9(green_set);
      med_pix.blue  = median9(blue_set);
   end

endmodule

`default_nettype wire

// ===== sv/median_filter_3x3_rgb_top.sv =====
// Top level of the 3x3 RGB median filter: position control, pipeline and result slots.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data (req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data (rsp_type)
//   csr      in         csr_write_en         csr_index, csr_data
//
// One item per cycle while results are taken; an item on the last row or column that also
// completes a median gives two results and holds the input while the second result drains.
// From accept to first result an item passes the line store read, the window and the slot.
// The line store read port and the median network set the single-cycle rate.
// Synchronous reset clears pipeline valids, position and window and loads the default sizes.
// A stalled result slot backs up through the window stage to req_ready.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_rgb_top
   import mfr_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [0:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [11:0] cfg_width_ff;
   logic [12:0] cfg_height_ff;
   logic [COL_W-1:0] last_col;
   logic [ROW_W-1:0] last_row;

   logic [COL_W-1:0] col_ff, col_in, cur_col;
   logic [ROW_W-1:0] row_ff, row_in, cur_row;
   logic accept;

   logic             s1_v_ff, s1_med_ff, s1_bord_ff, s1_ge1_ff, s1_ge2_ff;
   pix_type          s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;

   logic             s2_v_ff, s2_med_ff, s2_bord_ff;
   pix_type          s2_pix_ff;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;

   logic    med_v_ff, bord_v_ff;
   rsp_type med_ff, bord_ff;

   logic    out_free, s2_adv, s2_free, s1_adv, s1_free;
   pix_type near_q, far_q, near_pix, far_pix, med_pix;
   pix_type cur_pix;

   // size registers and clamped limits
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= FRAME_WIDTH_RESET;
         cfg_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  cfg_width_ff  <= csr_data[11:0];
            CSR_FRAME_HEIGHT: cfg_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_width_ff < 12'd3) begin
         last_col = COL_W'(2);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(cfg_width_ff - 12'd1);
      end
      if (cfg_height_ff < 13'd3) begin
         last_row = ROW_W'(2);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(cfg_height_ff - 13'd1);
      end
   end

   // pipeline flow
   assign out_free  = (!med_v_ff && !bord_v_ff) || (rsp_ready && (med_v_ff ^ bord_v_ff));
   assign s2_adv    = s2_v_ff && out_free;
   assign s2_free   = !s2_v_ff || s2_adv;
   assign s1_adv    = s1_v_ff && s2_free;
   assign s1_free   = !s1_v_ff || s1_adv;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   // position of the incoming item
   always_comb begin
      cur_col = req_data.frame_start ? '0 : col_ff;
      cur_row = req_data.frame_start ? '0 : row_ff;
      if (cur_col >= last_col) begin
         col_in = '0;
         row_in = (cur_row >= last_row) ? '0 : cur_row + 1'b1;
      end else begin
         col_in = cur_col + 1'b1;
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur_pix = '{red: req_data.red_in, green: req_data.green_in,
                      blue: req_data.blue_in};

   // stage one: item and line store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (accept) begin
         s1_v_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= cur_pix;
         s1_col_ff  <= cur_col;
         s1_row_ff  <= cur_row;
         s1_ge1_ff  <= cur_row != '0;
         s1_ge2_ff  <= cur_row >= ROW_W'(2);
         s1_med_ff  <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2)) &&
                       (cur_row <= last_row) && (cur_col <= last_col);
         s1_bord_ff <= (cur_row == '0) || (cur_col == '0) ||
                       (cur_row >= last_row) || (cur_col >= last_col);
      end
   end

   mfr_line_buffer #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_near (s1_pix_ff),
      .wr_far  (near_q),
      .near_q  (near_q),
      .far_q   (far_q)
   );

   assign near_pix = s1_ge1_ff ? near_q : '0;
   assign far_pix  = s1_ge2_ff ? far_q  : '0;

   // stage two: window
   mfr_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_adv),
      .far_pix  (far_pix),
      .near_pix (near_pix),
      .new_pix  (s1_pix_ff),
      .med_pix  (med_pix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_v_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_pix_ff  <= s1_pix_ff;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_med_ff  <= s1_med_ff;
         s2_bord_ff <= s1_bord_ff;
      end
   end

   // result slots: median first, then border pass-through
   always_ff @(posedge clock) begin
      if (reset) begin
         med_v_ff  <= 1'b0;
         bord_v_ff <= 1'b0;
      end else if (s2_adv) begin
         med_v_ff  <= s2_med_ff;
         bord_v_ff <= s2_bord_ff;
      end else if (rsp_ready) begin
         if (med_v_ff) begin
            med_v_ff <= 1'b0;
         end else begin
            bord_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         med_ff.red_out      <= med_pix.red;
         med_ff.green_out    <= med_pix.green;
         med_ff.blue_out     <= med_pix.blue;
         med_ff.out_row      <= 12'(s2_row_ff - 1'b1);
         med_ff.out_col      <= 11'(s2_col_ff - 1'b1);
         med_ff.is_border    <= 1'b0;
         med_ff.last_of_run  <= !s2_bord_ff;
         bord_ff.red_out     <= s2_pix_ff.red;
         bord_ff.green_out   <= s2_pix_ff.green;
         bord_ff.blue_out    <= s2_pix_ff.blue;
         bord_ff.out_row     <= 12'(s2_row_ff);
         bord_ff.out_col     <= 11'(s2_col_ff);
         bord_ff.is_border   <= 1'b1;
         bord_ff.last_of_run <= 1'b1;
      end
   end

   assign rsp_valid = med_v_ff || bord_v_ff;
   assign rsp_data  = med_v_ff ? med_ff : bord_ff;

   a_frame_start_pos : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_start) |=> (col_ff == COL_W'(1) && row_ff == '0))
      else $error("frame start did not restart the position");

   a_border_follows : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last_of_run) |=>
      (rsp_valid && rsp_data.is_border))
      else $error("border item missing after median item");

   a_border_last : assert property (@(posedge clock) disable iff (reset)
      (bord_v_ff && !med_v_ff) |-> (rsp_data.is_border && rsp_data.last_of_run))
      else $error("lone border item not marked last");

   a_window_hold : assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !out_free) |-> !s1_adv)
      else $error("window shifted under a held item");

endmodule

`default_nettype wire

// ===== verif/tb_median_filter_3x3_rgb_top.sv =====
// Self-checking testbench for the 3x3 RGB median filter: pixel streams, size changes, scoreboard.
`timescale 1ns / 1ps

module tb_median_filter_3x3_rgb_top;
   import mfr_pkg::*;

   localparam int MAX_COLS = 2048;
   localparam int MAX_ROWS = 4096;
   localparam int RANDOM_ITEMS = 1850;
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {
      TONE_LOW,
      TONE_EXTREME,
      TONE_HIGH,
      TONE_FULL
   } tone_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [0:0]            csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   median_filter_3x3_rgb_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   // filter state mirrored from the pixel stream
   pix_type     near_line [MAX_COLS];
   pix_type     far_line [MAX_COLS];
   pix_type     win [9] = '{default: '0};
   logic [11:0] row_pos = '0;
   logic [10:0] col_pos = '0;
   logic [11:0] cols_reg = FRAME_WIDTH_RESET;
   logic [12:0] rows_reg = FRAME_HEIGHT_RESET;

   req_type pixel_backlog [$];
   rsp_type outputs_due [$];
   rsp_type want_rsp;

   logic needs_restart = 1'b0;
   logic send_eager = 1'b0;
   logic take_eager = 1'b0;
   int   send_gap = 0;
   int   take_gap = 0;
   int   pixels_taken = 0;
   int   results_checked = 0;
   int   medians_seen = 0;
   int   borders_seen = 0;
   int   size_settings = 0;
   int   mismatches = 0;

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] middle_of_nine(input logic [8:0][7:0] v);
      int below;
      int level;
      for (int i = 0; i < 9; i++) begin
         below = 0;
         level = 0;
         for (int j = 0; j < 9; j++) begin
            if (v[j] < v[i]) below++;
            else if (v[j] == v[i]) level++;
         end
         if (below <= 4 && below + level >= 5) return v[i];
      end
      return v[4];
   endfunction

   task automatic filter_pixel(input req_type item);
      int unsigned     w;
      int unsigned     h;
      int unsigned     r;
      int unsigned     c;
      logic [8:0][7:0] reds;
      logic [8:0][7:0] greens;
      logic [8:0][7:0] blues;
      pix_type         px;
      rsp_type         res;
      logic            make_median;
      logic            make_border;
      w = clamp_dim(cols_reg, MAX_COLS);
      h = clamp_dim(rows_reg, MAX_ROWS);
      px = {item.red_in, item.green_in, item.blue_in};
      if (item.frame_start) begin
         row_pos = '0;
         col_pos = '0;
      end
      r = row_pos;
      c = col_pos;
      win[0] = win[1];
      win[1] = win[2];
      win[2] = (r >= 2) ? far_line[c] : '0;
      win[3] = win[4];
      win[4] = win[5];
      win[5] = (r >= 1) ? near_line[c] : '0;
      win[6] = win[7];
      win[7] = win[8];
      win[8] = px;
      far_line[c] = near_line[c];
      near_line[c] = px;
      for (int k = 0; k < 9; k++) begin
         reds[k] = win[k].red;
         greens[k] = win[k].green;
         blues[k] = win[k].blue;
      end
      make_median = r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1;
      make_border = r == 0 || c == 0 || r >= h - 1 || c >= w - 1;
      if (make_median) begin
         res.red_out = middle_of_nine(reds);
         res.green_out = middle_of_nine(greens);
         res.blue_out = middle_of_nine(blues);
         res.out_row = 12'(r - 1);
         res.out_col = 11'(c - 1);
         res.is_border = 1'b0;
         res.last_of_run = !make_border;
         outputs_due.push_back(res);
      end
      if (make_border) begin
         res.red_out = px.red;
         res.green_out = px.green;
         res.blue_out = px.blue;
         res.out_row = 12'(r);
         res.out_col = 11'(c);
         res.is_border = 1'b1;
         res.last_of_run = 1'b1;
         outputs_due.push_back(res);
      end
      if (c >= w - 1) begin
         col_pos = '0;
         row_pos = (r >= h - 1) ? 12'd0 : 12'(r + 1);
      end else begin
         col_pos = 11'(c + 1);
      end
   endtask

   function automatic string describe(input rsp_type x);
      return $sformatf("row %0d col %0d rgb %02h %02h %02h border %0b last %0b",
                       x.out_row, x.out_col, x.red_out, x.green_out, x.blue_out,
                       x.is_border, x.last_of_run);
   endfunction

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            filter_pixel(req_data);
            pixels_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pixel_backlog.pop_front();
               send_gap = send_eager ? 0 : $urandom_range(0, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.is_border) borders_seen++;
            else medians_seen++;
            if (outputs_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: %s", describe(rsp_data));
            end else begin
               want_rsp = outputs_due.pop_front();
               results_checked++;
               if (rsp_data.red_out !== want_rsp.red_out ||
                   rsp_data.green_out !== want_rsp.green_out ||
                   rsp_data.blue_out !== want_rsp.blue_out ||
                   rsp_data.out_row !== want_rsp.out_row ||
                   rsp_data.out_col !== want_rsp.out_col ||
                   rsp_data.is_border !== want_rsp.is_border ||
                   rsp_data.last_of_run !== want_rsp.last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch expected %s", describe(want_rsp));
                     $display("         actual   %s", describe(rsp_data));
                  end
               end
            end
            take_gap = take_eager ? 0 : $urandom_range(0, 9);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] channel_value(input tone_type tone);
      case (tone)
         TONE_LOW:     return 8'($urandom_range(0, 3));
         TONE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         TONE_HIGH:    return 8'($urandom_range(250, 255));
         default:      return 8'($urandom);
      endcase
   endfunction

   task automatic push_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic fs);
      req_type item;
      item.red_in = r;
      item.green_in = g;
      item.blue_in = b;
      item.frame_start = fs | needs_restart;
      needs_restart = 1'b0;
      pixel_backlog.push_back(item);
   endtask

   task automatic push_pixel(input logic fs, input tone_type tone);
      push_rgb(channel_value(tone), channel_value(tone), channel_value(tone), fs);
   endtask

   // a wider row would read line store columns that this frame never wrote, so restart
   task automatic write_reg(input csr_index_type idx, input logic [12:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) begin
         if (clamp_dim(val[11:0], MAX_COLS) > clamp_dim(cols_reg, MAX_COLS))
            needs_restart = 1'b1;
         cols_reg = val[11:0];
      end else begin
         rows_reg = val;
      end
   endtask

   task automatic wait_idle();
      while (pixel_backlog.size() != 0 || req_valid || outputs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [12:0] pick_cols();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 13'($urandom_range(3, 12));
      if (roll < 7) return 13'($urandom_range(0, 2));
      if (roll < 9) return 13'($urandom_range(13, 40));
      return 13'($urandom);
   endfunction

   function automatic logic [12:0] pick_rows();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return 13'($urandom_range(3, 8));
      if (roll < 15) return 13'($urandom_range(0, 2));
      if (roll < 18) return 13'($urandom_range(9, 30));
      return 13'($urandom);
   endfunction

   initial begin
      int unsigned random_sent;
      int unsigned phase_len;
      tone_type    tone;
      logic        noisy;
      logic        fs;
      random_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // smallest frame: one interior pixel, wrap, then restart mid-frame
      write_reg(CSR_FRAME_WIDTH, 13'd3);
      write_reg(CSR_FRAME_HEIGHT, 13'd3);
      size_settings++;
      push_rgb(8'hFF, 8'h00, 8'h80, 1'b1);
      push_rgb(8'h00, 8'hFF, 8'h01, 1'b0);
      push_rgb(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
      push_rgb(8'h7F, 8'h80, 8'h02, 1'b0);
      push_rgb(8'hFF, 8'h00, 8'h04, 1'b0);
      push_rgb(8'h01, 8'hFE, 8'h08, 1'b0);
      push_rgb(8'hFF, 8'h01, 8'h10, 1'b0);
      push_rgb(8'h00, 8'hFF, 8'h20, 1'b0);
      push_rgb(8'h55, 8'hAA, 8'h40, 1'b0);
      push_rgb(8'hAA, 8'h55, 8'h80, 1'b0);
      push_rgb(8'h0F, 8'hF0, 8'hFF, 1'b0);
      push_rgb(8'hF0, 8'h0F, 8'h00, 1'b0);
      push_rgb(8'h80, 8'h80, 8'h80, 1'b1);
      push_rgb(8'h80, 8'h7F, 8'h81, 1'b0);
      wait_idle();

      // out-of-range sizes, then cut the frame short mid-row
      write_reg(CSR_FRAME_WIDTH, 13'd0);
      write_reg(CSR_FRAME_HEIGHT, 13'h1FFF);
      size_settings++;
      for (int i = 0; i < 8; i++) push_pixel(i == 0, TONE_EXTREME);
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, 13'd1);
      size_settings++;
      push_pixel(1'b0, TONE_LOW);
      push_pixel(1'b0, TONE_LOW);
      wait_idle();

      // widest row, reaching the last column once
      write_reg(CSR_FRAME_WIDTH, 13'h0FFF);
      write_reg(CSR_FRAME_HEIGHT, 13'd3);
      size_settings++;
      send_eager = 1'b1;
      take_eager = 1'b1;
      for (int i = 0; i < MAX_COLS + 4; i++) push_pixel(1'b0, TONE_FULL);
      wait_idle();

      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) write_reg(CSR_FRAME_WIDTH, pick_cols());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_FRAME_HEIGHT, pick_rows());
         size_settings++;
         send_eager = ($urandom_range(0, 4) == 0);
         take_eager = ($urandom_range(0, 4) == 0);
         tone = tone_type'($urandom_range(0, 3));
         noisy = ($urandom_range(0, 7) == 0);
         phase_len = $urandom_range(10, 90);
         for (int i = 0; i < phase_len; i++) begin
            if (i == 0) fs = 1'($urandom_range(0, 1));
            else if (noisy) fs = ($urandom_range(0, 3) == 0);
            else fs = ($urandom_range(0, 59) == 0);
            push_pixel(fs, $urandom_range(0, 1) ? tone : TONE_FULL);
            random_sent++;
         end
         wait_idle();
      end

      $display("%0d pixels through %0d frame size settings, %0d results checked",
               pixels_taken, size_settings, results_checked);
      $display("%0d medians and %0d border pass-throughs, %0d mismatches",
               medians_seen, borders_seen, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== median_filter_3x3_rgb_top.f =====
sv/mfr_pkg.sv
sv/mfr_line_buffer.sv
sv/mfr_window.sv
sv/median_filter_3x3_rgb_top.sv
verif/tb_median_filter_3x3_rgb_top.sv
